@@ rtl/cslp_pkg.sv @@
// ----------------------------------------------------------------------------
// cslp_pkg: shared types and constants of the command script line parser
// Character codes, table limits, parse mode encoding and the transaction
// payload records used by the channels and the internal stages.
// ----------------------------------------------------------------------------
`default_nettype none

package cslp_pkg;

   // table limits
   localparam int MAX_COMMANDS = 16;
   localparam int SCRIPT_BYTES = 512;

   // saturation limits of the decimal fields
   localparam logic [30:0] TRIG_MAX = 31'h7FFF_FFFF;
   localparam logic [7:0]  PORT_MAX = 8'd255;

   // character codes
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_LC_A  = 8'h61;
   localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
   localparam logic [7:0] CASE_DIFF  = 8'h20;

   // command kinds with a payload rule
   localparam logic [7:0] KIND_TEXT = 8'h54;  // T
   localparam logic [7:0] KIND_BIN  = 8'h42;  // B
   localparam logic [7:0] KIND_NMEA = 8'h4E;  // N
   localparam logic [7:0] KIND_HEX  = 8'h48;  // H
   localparam logic [7:0] KIND_SREC = 8'h53;  // S

   // line parse position
   typedef enum logic [2:0] {
      MODE_TYPE  = 3'd0,
      MODE_GAP1  = 3'd1,
      MODE_GAP   = 3'd2,
      MODE_AT    = 3'd3,
      MODE_PORT1 = 3'd4,
      MODE_PORT  = 3'd5,
      MODE_BODY  = 3'd6,
      MODE_NOTE  = 3'd7
   } cslp_mode_type;

   // result transaction payload
   typedef struct packed {
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic        command_end;
      logic [3:0]  command_index;
      logic [7:0]  command_kind;
      logic [30:0] trigger_count;
      logic [7:0]  out_port;
      logic [8:0]  payload_offset;
      logic [8:0]  payload_length;
   } cslp_rsp_type;

   // held input byte handed to the parse core
   typedef struct packed {
      logic       valid;
      logic [7:0] script_byte;
   } cslp_item_type;

   // parse core result toward the output register
   typedef struct packed {
      logic         valid;
      cslp_rsp_type data;
   } cslp_result_type;

endpackage

`default_nettype wire

@@ rtl/cslp_req_if.sv @@
// ----------------------------------------------------------------------------
// cslp_req_if: script byte channel
// Valid/ready channel carrying one raw script byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface cslp_req_if;

   logic       valid;
   logic       ready;
   logic [7:0] script_byte;

   modport source (output valid, output script_byte, input ready);
   modport sink   (input valid, input script_byte, output ready);

endinterface

`default_nettype wire

@@ rtl/cslp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// cslp_rsp_if: parser result channel
// Valid/ready channel carrying one payload byte and/or command record.
// ----------------------------------------------------------------------------
`default_nettype none

interface cslp_rsp_if import cslp_pkg::*; ();

   logic         valid;
   logic         ready;
   cslp_rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

@@ rtl/cslp_in_stage.sv @@
// ----------------------------------------------------------------------------
// cslp_in_stage: input register
// Captures one script byte per transaction and holds it until the parse
// core consumes it; refills in the same cycle the held byte is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module cslp_in_stage import cslp_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   cslp_req_if.sink     req_chan,
   input  wire logic    take,
   output cslp_item_type item
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       load;

   // ready when empty or when the held byte leaves this cycle
   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;

   // occupancy and data update
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = req_chan.script_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign item.valid       = valid_ff;
   assign item.script_byte = byte_ff;

endmodule

`default_nettype wire

@@ rtl/cslp_parse_core.sv @@
// ----------------------------------------------------------------------------
// cslp_parse_core: line parser state and per-byte update
// Tracks the position in the current line, accumulates the decimal fields,
// filters or packs payload bytes and builds the result record for a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module cslp_parse_core import cslp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cslp_item_type item,
   input  wire logic          step,
   output cslp_result_type    result
);

   cslp_mode_type mode_ff, mode_in;
   logic [7:0]    kind_ff, kind_in;
   logic [30:0]   trig_ff, trig_in;
   logic [7:0]    port_ff, port_in;
   logic [7:0]    hex_ff, hex_in;
   logic          nib_ff, nib_in;
   logic [8:0]    length_ff, length_in;
   logic [8:0]    start_ff, start_in;
   logic [8:0]    write_ff, write_in;
   logic [4:0]    index_ff, index_in;
   logic [9:0]    seen_ff, seen_in;

   logic [7:0]  c;
   logic        active;
   logic        live;
   logic        blank;
   logic        is_lf;
   logic        digit;
   logic [3:0]  digit_val;
   logic [7:0]  upper;
   logic [34:0] trig_sum;
   logic [30:0] trig_next;
   logic [11:0] port_sum;
   logic [7:0]  port_next;
   logic [7:0]  hex_val;
   logic [7:0]  hex_pack;
   logic        pv;
   logic [7:0]  pb;
   logic        endf;

   // byte classification
   assign c         = item.script_byte;
   assign active    = step && item.valid && (seen_ff < 10'(SCRIPT_BYTES));
   assign live      = index_ff < 5'(MAX_COMMANDS);
   assign is_lf     = (c == CHAR_LF);
   assign blank     = (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_CR) || is_lf;
   assign digit     = (c >= CHAR_0) && (c <= CHAR_9);
   assign digit_val = 4'(c - CHAR_0);
   assign upper     = ((c >= CHAR_LC_A) && (c <= CHAR_LC_Z)) ? (c - CASE_DIFF) : c;

   // decimal accumulate with saturation: acc * 10 + digit
   assign trig_sum  = {1'b0, trig_ff, 3'b000} + {3'b000, trig_ff, 1'b0}
                    + {31'd0, digit_val};
   assign trig_next = !digit ? trig_ff
                    : ((trig_sum > {4'd0, TRIG_MAX}) ? TRIG_MAX : trig_sum[30:0]);
   assign port_sum  = {1'b0, port_ff, 3'b000} + {3'b000, port_ff, 1'b0}
                    + {8'd0, digit_val};
   assign port_next = !digit ? port_ff
                    : ((port_sum > {4'd0, PORT_MAX}) ? PORT_MAX : port_sum[7:0]);

   // hex nibble value and shift into the packer
   assign hex_val  = (c < CHAR_A) ? (c - CHAR_0) : (c - CHAR_A + 8'd10);
   assign hex_pack = {hex_ff[3:0], 4'b0000} | hex_val;

   // next line position
   always_comb begin
      mode_in = mode_ff;
      if (active) begin
         unique case (mode_ff)
            MODE_TYPE:  mode_in = (upper == CHAR_SEMI) ? MODE_NOTE : MODE_GAP1;
            MODE_GAP1:  mode_in = MODE_GAP;
            MODE_GAP:   if (!blank) mode_in = MODE_AT;
            MODE_AT:    if (blank) mode_in = MODE_PORT1;
            MODE_PORT1: mode_in = MODE_PORT;
            MODE_PORT:  if (blank) mode_in = MODE_BODY;
            MODE_BODY:  if (is_lf) mode_in = MODE_TYPE;
            MODE_NOTE:  if (is_lf) mode_in = MODE_TYPE;
            default:    mode_in = MODE_TYPE;
         endcase
      end
   end

   // field accumulation, payload rule and record
   always_comb begin
      kind_in   = kind_ff;
      trig_in   = trig_ff;
      port_in   = port_ff;
      hex_in    = hex_ff;
      nib_in    = nib_ff;
      length_in = length_ff;
      start_in  = start_ff;
      write_in  = write_ff;
      index_in  = index_ff;
      seen_in   = seen_ff;
      pv        = 1'b0;
      pb        = 8'd0;
      endf      = 1'b0;
      if (active) begin
         seen_in = seen_ff + 10'd1;
         unique case (mode_ff)
            MODE_TYPE: begin
               kind_in = upper;
               trig_in = 31'd0;
               port_in = 8'd0;
            end
            MODE_GAP, MODE_AT: begin
               if (!blank) trig_in = trig_next;
            end
            MODE_PORT1: begin
               port_in = port_next;
            end
            MODE_PORT: begin
               if (blank) begin
                  length_in = 9'd0;
               end else begin
                  port_in = port_next;
               end
            end
            MODE_BODY: begin
               if (live) begin
                  case (kind_ff) inside
                     KIND_TEXT: begin
                        pv = 1'b1;
                        pb = c;
                     end
                     KIND_BIN, KIND_NMEA: begin
                        if (c >= CHAR_SPACE) begin
                           pv = 1'b1;
                           pb = c;
                        end
                     end
                     KIND_HEX, KIND_SREC: begin
                        if (!blank) begin
                           if (nib_ff) begin
                              pv     = 1'b1;
                              pb     = hex_pack;
                              hex_in = 8'd0;
                              nib_in = 1'b0;
                           end else begin
                              hex_in = hex_pack;
                              nib_in = 1'b1;
                           end
                        end
                     end
                     default: ;
                  endcase
                  if (pv) begin
                     length_in = length_ff + 9'd1;
                     write_in  = write_ff + 9'd1;
                  end
                  if (is_lf) begin
                     endf     = 1'b1;
                     index_in = index_ff + 5'd1;
                     start_in = write_in;
                  end
               end
            end
            MODE_NOTE: begin
               if (is_lf) start_in = write_ff;
            end
            default: ;
         endcase
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_TYPE;
         kind_ff   <= 8'd0;
         trig_ff   <= 31'd0;
         port_ff   <= 8'd0;
         hex_ff    <= 8'd0;
         nib_ff    <= 1'b0;
         length_ff <= 9'd0;
         start_ff  <= 9'd0;
         write_ff  <= 9'd0;
         index_ff  <= 5'd0;
         seen_ff   <= 10'd0;
      end else begin
         mode_ff   <= mode_in;
         kind_ff   <= kind_in;
         trig_ff   <= trig_in;
         port_ff   <= port_in;
         hex_ff    <= hex_in;
         nib_ff    <= nib_in;
         length_ff <= length_in;
         start_ff  <= start_in;
         write_ff  <= write_in;
         index_ff  <= index_in;
         seen_ff   <= seen_in;
      end
   end

   // result record for this byte
   assign result.valid               = pv || endf;
   assign result.data.payload_valid  = pv;
   assign result.data.payload_byte   = pb;
   assign result.data.command_end    = endf;
   assign result.data.command_index  = index_ff[3:0];
   assign result.data.command_kind   = kind_ff;
   assign result.data.trigger_count  = trig_ff;
   assign result.data.out_port       = port_ff;
   assign result.data.payload_offset = start_ff;
   assign result.data.payload_length = length_in;

endmodule

`default_nettype wire

@@ rtl/cslp_out_stage.sv @@
// ----------------------------------------------------------------------------
// cslp_out_stage: result register
// Holds one result transaction until the sink takes it and tells the
// parse core when a new byte may be processed.
// ----------------------------------------------------------------------------
`default_nettype none

module cslp_out_stage import cslp_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire cslp_result_type result,
   input  wire logic            step,
   output logic                 free,
   cslp_rsp_if.source           rsp_chan
);

   logic         valid_ff, valid_in;
   cslp_rsp_type data_ff, data_in;

   // room for a new result when empty or being drained
   assign free = !valid_ff || rsp_chan.ready;

   // register update
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (free) begin
         valid_in = step && result.valid;
         data_in  = result.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.data  = data_ff;

endmodule

`default_nettype wire

@@ rtl/command_script_line_parser.sv @@
// ----------------------------------------------------------------------------
// command_script_line_parser: command script line parser top level
// Parses a command script byte stream into payload bytes and command records.
// ----------------------------------------------------------------------------
// The parser takes one script byte per cycle while the result channel is not
// stalled and returns at most one result transaction per byte, held first in
// the input register and then the result register, with the whole line parse
// step done between them. Bytes that yield no result (line header, blanks,
// filtered payload, comment lines, bytes past the first 512) are consumed
// at the same rate. A stalled result channel holds the result register and
// then the input register; the byte rate is limited only by the sink.
// ----------------------------------------------------------------------------
`default_nettype none

module command_script_line_parser import cslp_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   cslp_req_if.sink   req_chan,
   cslp_rsp_if.source rsp_chan
);

   cslp_item_type   item;
   cslp_result_type result;
   logic            free;
   logic            step;

   // the held byte is parsed whenever the result register has room
   assign step = item.valid && free;

   cslp_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (step),
      .item     (item)
   );

   cslp_parse_core u_parse_core (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .step   (step),
      .result (result)
   );

   cslp_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .step     (step),
      .free     (free),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire
